// ===== hdl/lkvc_pkg.sv =====
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 31;
    localparam int CFG_W = 5;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

endpackage

// ===== hdl/lkvc_cell.sv =====
module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  logic [KEY_W-1:0] lookup_key,
    input  entry_t           prev_entry,
    output entry_t           cur_entry,
    output logic             match
);

    logic             valid_reg;
    logic             valid_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (shift_en)
        begin
            valid_next = prev_entry.valid;
            key_next   = prev_entry.key;
            value_next = prev_entry.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // key and value are only looked at while valid
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign match = valid_reg && (key_reg == lookup_key);

    assign cur_entry.valid = valid_reg;
    assign cur_entry.key   = key_reg;
    assign cur_entry.value = value_reg;

endmodule

// ===== hdl/lru_key_value_cache_core.sv =====
// channel    | direction | handshake                     | payload
// -----------+-----------+-------------------------------+---------------------------
// request    | in        | start, busy (taken: start & !busy) | mode, key, value
// result     | out       | done (one-cycle strobe)       | found, read_value, evicted
// config     | in        | cfg_valid, cfg_ready          | cfg_data (active_entries)
//
// a request is registered at acceptance; in the next cycle every cell compares its key
// and, unless a get misses, the cells up to the hit, free or lru position shift one
// toward the least recent end; a result strobes done in the cycle after that, and a new
// request is not taken while busy is high (busy is high for the compare cycle only)
// rst_n clears the valid bits, the occupancy and the capacity (to 16) at once
// the result side cannot stall; cfg_ready is always high
module lru_key_value_cache_core
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             mode,
    input  logic [KEY_W-1:0] key,
    input  logic [VAL_W-1:0] value,
    output logic             done,
    output logic             found,
    output logic [VAL_W-1:0] read_value,
    output logic             evicted,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic             pend_reg;
    logic             pend_next;
    logic             mode_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;

    logic [CFG_W-1:0] active_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic [CNT_W-1:0] occ_minus;

    logic             done_reg;
    logic             found_reg;
    logic [VAL_W-1:0] read_value_reg;
    logic             evicted_reg;

    entry_t           cell_q   [ENTRIES];
    entry_t           cell_in  [ENTRIES];
    logic             cell_hit [ENTRIES];
    logic             cell_en  [ENTRIES];
    entry_t           head;

    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [VAL_W-1:0] hit_value;
    logic [CMP_W-1:0] cap;
    logic [CMP_W-1:0] occ_ext;
    logic             full;
    logic             update;
    logic [IDX_W-1:0] bound;
    logic             accept;

    assign accept    = start && !pend_reg;
    assign busy      = pend_reg;
    assign cfg_ready = 1'b1;

    // row of cells, position 0 holds the most recent entry
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign cell_in[g] = head;
        end
        else
        begin : g_link
            assign cell_in[g] = cell_q[g-1];
        end

        assign cell_en[g] = update && (IDX_W'(g) <= bound);

        lkvc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (cell_en[g]),
            .lookup_key (key_reg),
            .prev_entry (cell_in[g]),
            .cur_entry  (cell_q[g]),
            .match      (cell_hit[g])
        );
    end

    // keys are unique, so at most one cell matches
    always_comb
    begin
        hit       = 1'b0;
        hit_idx   = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cell_hit[i])
            begin
                hit       = 1'b1;
                hit_idx   = hit_idx | IDX_W'(i);
                hit_value = hit_value | cell_q[i].value;
            end
        end
    end

    always_comb
    begin
        if (active_reg == '0)
        begin
            cap = CMP_W'(1);
        end
        else if (CMP_W'(active_reg) > CMP_W'(ENTRIES))
        begin
            cap = CMP_W'(ENTRIES);
        end
        else
        begin
            cap = CMP_W'(active_reg);
        end
    end

    assign occ_ext   = CMP_W'(occ_reg);
    assign full      = (occ_ext >= cap);
    assign occ_minus = occ_reg - CNT_W'(1);
    assign update    = pend_reg && (hit || (mode_reg == MODE_PUT));

    // deepest cell that moves: the hit cell, the first free cell, or the lru cell
    always_comb
    begin
        priority if (hit)
        begin
            bound = hit_idx;
        end
        else if (!full)
        begin
            bound = occ_reg[IDX_W-1:0];
        end
        else
        begin
            bound = occ_minus[IDX_W-1:0];
        end
    end

    assign head.valid = 1'b1;
    assign head.key   = key_reg;
    assign head.value = (mode_reg == MODE_PUT) ? value_reg : hit_value;

    always_comb
    begin
        occ_next = occ_reg;
        if (pend_reg && (mode_reg == MODE_PUT) && !hit && !full)
        begin
            occ_next = occ_reg + CNT_W'(1);
        end
    end

    assign pend_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            occ_reg    <= '0;
            active_reg <= CFG_RESET;
        end
        else
        begin
            pend_reg <= pend_next;
            done_reg <= pend_reg;
            occ_reg  <= occ_next;
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            key_reg   <= key;
            value_reg <= value;
        end
        if (pend_reg)
        begin
            found_reg      <= hit;
            read_value_reg <= (hit && (mode_reg == MODE_GET)) ? hit_value : '0;
            evicted_reg    <= (mode_reg == MODE_PUT) && !hit && full;
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign read_value = read_value_reg;
    assign evicted    = evicted_reg;

endmodule

// ===== dv/lru_key_value_cache_core_test.sv =====
`timescale 1ns / 100ps

module lru_key_value_cache_core_test;
    import lkvc_pkg::*;

    localparam int ENTRIES = 16;

    typedef struct {
        logic             op;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
    } cache_req_t;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] rd;
        logic             evicted;
    } lookup_result_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             mode = MODE_GET;
    logic [KEY_W-1:0] key = '0;
    logic [VAL_W-1:0] value = '0;
    logic             done;
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    lru_key_value_cache_core #(.ENTRIES(ENTRIES)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .key        (key),
        .value      (value),
        .done       (done),
        .found      (found),
        .read_value (read_value),
        .evicted    (evicted),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // cache shadow: contents, recency order and capacity register
    logic [KEY_W-1:0] shadow_key [ENTRIES];
    logic [VAL_W-1:0] shadow_val [ENTRIES];
    bit               shadow_valid [ENTRIES];
    int unsigned      shadow_rank [ENTRIES];
    int unsigned      shadow_fill = 0;
    logic [CFG_W-1:0] capacity_reg = CFG_RESET;

    cache_req_t       pending_reqs [$];
    lookup_result_t   expected_results [$];
    logic [KEY_W-1:0] key_pool [$];
    cache_req_t       next_req;
    lookup_result_t   want;

    bit took = 1'b0;
    bit no_gaps = 1'b0;
    int gap_left = 0;
    int n_issued = 0;
    int n_taken = 0;
    int n_results = 0;
    int n_hits = 0;
    int n_evictions = 0;
    int n_cfg_writes = 0;
    int errors = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void promote(int s);
        int i;
        for (i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && i != s && shadow_rank[i] < shadow_rank[s])
                shadow_rank[i]++;
        shadow_rank[s] = 0;
    endfunction

    function automatic lookup_result_t cache_access(logic op, logic [KEY_W-1:0] k,
                                                    logic [VAL_W-1:0] v);
        lookup_result_t r;
        int i;
        int hit;
        int slot;
        int unsigned cap;
        r = '0;
        hit = -1;
        slot = -1;
        for (i = 0; i < ENTRIES; i++)
            if (hit < 0 && shadow_valid[i] && shadow_key[i] == k)
                hit = i;
        r.found = (hit >= 0);
        cap = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
        if (op == MODE_GET)
        begin
            if (hit >= 0)
            begin
                r.rd = shadow_val[hit];
                promote(hit);
            end
        end
        else if (hit >= 0)
        begin
            shadow_val[hit] = v;
            promote(hit);
        end
        else if (shadow_fill < cap)
        begin
            for (i = ENTRIES - 1; i >= 0; i--)
                if (!shadow_valid[i])
                    slot = i;
            // everyone else gets one step older
            for (i = 0; i < ENTRIES; i++)
                if (shadow_valid[i])
                    shadow_rank[i]++;
            shadow_valid[slot] = 1'b1;
            shadow_key[slot] = k;
            shadow_val[slot] = v;
            shadow_rank[slot] = 0;
            shadow_fill++;
        end
        else
        begin
            for (i = 0; i < ENTRIES; i++)
                if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > shadow_rank[slot]))
                    slot = i;
            shadow_key[slot] = k;
            shadow_val[slot] = v;
            promote(slot);
            r.evicted = 1'b1;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!start || took))
        begin
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                next_req = pending_reqs.pop_front();
                n_issued++;
                start <= 1'b1;
                mode <= next_req.op;
                key <= next_req.k;
                value <= next_req.v;
                gap_left <= pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // result checker and request tracker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no request pending: found=%0b read_value=%0h evicted=%0b",
                             $time, found, read_value, evicted);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    n_results++;
                    if (found !== want.found)
                    begin
                        $display("%0t: found mismatch: expected %0b, got %0b",
                                 $time, want.found, found);
                        errors++;
                    end
                    if (read_value !== want.rd)
                    begin
                        $display("%0t: read_value mismatch: expected %0h, got %0h",
                                 $time, want.rd, read_value);
                        errors++;
                    end
                    if (evicted !== want.evicted)
                    begin
                        $display("%0t: evicted mismatch: expected %0b, got %0b",
                                 $time, want.evicted, evicted);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                want = cache_access(mode, key, value);
                if (mode == MODE_GET && want.found)
                    n_hits++;
                if (want.evicted)
                    n_evictions++;
                expected_results.push_back(want);
                n_taken++;
            end
            took <= start && !busy;
        end
    end

    task automatic queue_request(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        cache_req_t r;
        r.op = op;
        r.k = k;
        r.v = v;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || n_issued != n_taken || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] cap);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        capacity_reg = cap;
        n_cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 95)
            return $urandom;
        return r[0] ? '1 : '0;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 8)
            return '1;
        return VAL_W'($urandom);
    endfunction

    logic [CFG_W-1:0] phase_caps [10] = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31,
                                         5'd8, 5'd2, 5'd16, 5'd5, 5'd12};

    initial
    begin
        int ph;
        int n;
        int pool_size;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty cache, extremes of key and value, update in place
        queue_request(MODE_GET, '0, '0);
        queue_request(MODE_GET, '1, '1);
        queue_request(MODE_PUT, '0, '0);
        queue_request(MODE_PUT, '1, '1);
        queue_request(MODE_GET, '0, '1);
        queue_request(MODE_GET, '1, '0);
        queue_request(MODE_PUT, '1, 31'h2aaa_aaaa);
        queue_request(MODE_GET, '1, '0);
        queue_request(MODE_PUT, 32'h5555_5555, 31'h5555_5555);
        queue_request(MODE_PUT, 32'haaaa_aaaa, 31'h1);
        wait_idle();

        // capacity lowered below occupancy: new keys evict
        write_capacity(5'd2);
        queue_request(MODE_PUT, 32'h1234_5678, 31'h3);
        queue_request(MODE_GET, '0, '0);
        queue_request(MODE_GET, 32'h1234_5678, '0);

        // zero capacity acts as one
        write_capacity(5'd0);
        queue_request(MODE_PUT, 32'h9, 31'h7);
        queue_request(MODE_PUT, 32'h9, 31'h8);
        queue_request(MODE_GET, 32'haaaa_aaaa, '0);
        queue_request(MODE_GET, 32'h9, '0);

        // oversized capacity saturates to the full array
        write_capacity(5'd31);
        queue_request(MODE_PUT, 32'h100, 31'h100);
        queue_request(MODE_PUT, 32'h200, 31'h200);
        queue_request(MODE_PUT, 32'h300, 31'h300);
        queue_request(MODE_GET, 32'h100, '0);
        queue_request(MODE_GET, '1, '0);

        for (ph = 0; ph < 10; ph++)
        begin
            write_capacity(phase_caps[ph]);
            no_gaps = (ph % 3 == 2);
            key_pool.delete();
            pool_size = $urandom_range(2, 20);
            for (n = 0; n < pool_size; n++)
                key_pool.push_back($urandom);
            for (n = 0; n < 110; n++)
            begin
                queue_request($urandom_range(0, 1) ? MODE_PUT : MODE_GET, pick_key(), pick_value());
                if (ph == 4 && n == 55)
                    wait_idle();
            end
        end
        no_gaps = 1'b0;

        wait_idle();
        repeat (10) @(posedge clk);
        $display("%0d requests over %0d capacity writes: %0d results, %0d get hits, %0d evictions",
                 n_taken, n_cfg_writes, n_results, n_hits, n_evictions);
        if (errors == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
